// ===== hw/rtl/hpt_pkg.sv =====
// Package: types, constants and helpers for the homogeneous point transform.
package hpt_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int COEFF_WIDTH   = 32;
  localparam int ACC_WIDTH     = 2 * COEFF_WIDTH + 4;
  localparam int NUM_WIDTH     = ACC_WIDTH + FRACTION_BITS;

  typedef logic signed [COEFF_WIDTH-1:0] coeff_t;
  typedef logic signed [ACC_WIDTH-1:0]   acc_t;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_CONCAT   = 3'd1,
    OP_XFORM    = 3'd2,
    OP_ROTATE   = 3'd3,
    OP_ROT_XLAT = 3'd4,
    OP_IDENTITY = 3'd5
  } opcode_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               range_fault;
  } out_word_t;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  localparam int ONE_RAW = (FRACTION_BITS >= COEFF_WIDTH - 1) ?
                           ((1 << (COEFF_WIDTH - 1)) - 1) : (1 << FRACTION_BITS);
  localparam coeff_t COEFF_ONE = coeff_t'(ONE_RAW);

  function automatic coeff_t ident_elem(input logic [3:0] idx);
    return (idx[1:0] == idx[3:2]) ? COEFF_ONE : '0;
  endfunction

  // saturate an accumulator-wide value to the coefficient width
  function automatic coeff_t sat_coeff(input acc_t a);
    acc_t mx;
    acc_t mn;
    mx = acc_t'({1'b0, {(COEFF_WIDTH-1){1'b1}}});
    mn = ~mx;
    if (a > mx) return coeff_t'(mx);
    if (a < mn) return coeff_t'(mn);
    return coeff_t'(a);
  endfunction

  function automatic logic sat_ovf32(input logic signed [NUM_WIDTH-1:0] a);
    return (a > $signed({{(NUM_WIDTH-31){1'b0}}, {31{1'b1}}})) ||
           (a < $signed({{(NUM_WIDTH-31){1'b1}}, {31{1'b0}}}));
  endfunction

  function automatic logic [31:0] sat32(input logic signed [NUM_WIDTH-1:0] a);
    if (a > $signed({{(NUM_WIDTH-31){1'b0}}, {31{1'b1}}})) return 32'h7fff_ffff;
    if (a < $signed({{(NUM_WIDTH-31){1'b1}}, {31{1'b0}}})) return 32'h8000_0000;
    return a[31:0];
  endfunction

endpackage

// ===== hw/rtl/hpt_divider.sv =====
// Radix-2 restoring divider for the homogeneous divide, one quotient bit a cycle.
module hpt_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hpt_pkg::div_ctl_t                    ctl_i,
  input  logic [hpt_pkg::NUM_WIDTH-1:0]        num_i,
  input  logic [hpt_pkg::ACC_WIDTH-1:0]        den_i,
  output hpt_pkg::div_sts_t                    sts_o,
  output logic [hpt_pkg::NUM_WIDTH-1:0]        quo_o,
  output logic                                 rem_nz_o
);
  import hpt_pkg::*;

  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [NUM_WIDTH-1:0] n_q, n_d, q_q, q_d;
  logic [ACC_WIDTH:0]   r_q, r_d, d_q, d_d, shr;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    n_d    = n_q;
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    shr    = {r_q[ACC_WIDTH-1:0], n_q[NUM_WIDTH-1]};
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NUM_WIDTH);
      n_d    = num_i;
      q_d    = '0;
      r_d    = '0;
      d_d    = {1'b0, den_i};
    end else if (busy_q) begin
      n_d = {n_q[NUM_WIDTH-2:0], 1'b0};
      if (shr >= d_q) begin
        r_d = shr - d_q;
        q_d = {q_q[NUM_WIDTH-2:0], 1'b1};
      end else begin
        r_d = shr;
        q_d = {q_q[NUM_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    q_q <= q_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = q_q;
  assign rem_nz_o   = (r_q != '0);

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without busy");
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider busy with zero count");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> busy_q) else $error("divider did not start");
endmodule

// ===== hw/rtl/homogeneous_point_transform.sv =====
// Top level: matrix store, shared MAC sequencer and result register.
// Sequence from the accepting edge to out_valid_o: rotate/rotate-translate run the MAC
// sequence, then the output load; transform adds three divides (skipped if w is 0) before it.
// Load, identity and unused opcodes complete on acceptance; concatenate returns to idle.
// One word in flight; a held result only stalls the sequencer at the output load.
// Reset (async, active low) sets both matrices to identity and empties the output.
module homogeneous_point_transform (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hpt_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hpt_pkg::out_word_t  out_data_o
);
  import hpt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CMAC  = 6'b000010,
    S_PMAC  = 6'b000100,
    S_DIV   = 6'b001000,
    S_DWAIT = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e       state_q, state_d;
  coeff_t       cur_q [16];
  coeff_t       stg_q [16];
  coeff_t       tmp_q [16];
  logic [5:0]   step_q, step_d;
  logic [2:0]   op_q;
  coeff_t       pt_q [3];
  acc_t         acc_q, acc_d;
  acc_t         pacc_q [4];
  logic [1:0]   coord_q, coord_d;
  logic         fault_q, fault_d;
  logic [31:0]  res_q [3];
  logic         ov_q;
  out_word_t    obuf_q;
  logic         mul_valid_q;
  logic signed [2*COEFF_WIDTH-1:0] prod_q;
  coeff_t       ma, mb;
  logic         accept;
  logic         out_load;
  logic         sel_neg;
  logic [NUM_WIDTH-1:0] div_num;
  logic [ACC_WIDTH-1:0] div_den;
  div_ctl_t     div_ctl;
  div_sts_t     div_sts;
  logic [NUM_WIDTH-1:0] div_quo;
  logic         div_rem_nz;
  acc_t         cur_num, wacc;
  logic signed [NUM_WIDTH-1:0] qs;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = obuf_q;
  // result register is free or being emptied this cycle
  assign out_load    = (state_q == S_OUT) && (!ov_q || !out_stall_i);

  // operand select: concat step = i*16+j*4+k, point step = j*4+i (i=3 -> row 3 times 1.0, or 0 for rotate)
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == S_CMAC) begin
      ma = tmp_q[{step_q[5:4], step_q[1:0]}];
      mb = stg_q[{step_q[1:0], step_q[3:2]}];
    end else begin
      mb = cur_q[{step_q[1:0], step_q[3:2]}];
      ma = (step_q[1:0] == 2'd3) ? COEFF_ONE : pt_q[step_q[1:0]];
      if (step_q[1:0] == 2'd3 && op_q == OP_ROTATE) ma = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
  end

  assign wacc    = pacc_q[3];
  assign cur_num = pacc_q[coord_q];
  assign sel_neg = cur_num[ACC_WIDTH-1] ^ wacc[ACC_WIDTH-1];
  assign div_num = NUM_WIDTH'(cur_num[ACC_WIDTH-1] ? -cur_num : cur_num) << FRACTION_BITS;
  assign div_den = wacc[ACC_WIDTH-1] ? ACC_WIDTH'(-wacc) : ACC_WIDTH'(wacc);
  assign div_ctl.start = (state_q == S_DIV) && (wacc != '0);

  hpt_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (div_ctl),
    .num_i   (div_num),
    .den_i   (div_den),
    .sts_o   (div_sts),
    .quo_o   (div_quo),
    .rem_nz_o(div_rem_nz)
  );

  always_comb begin
    qs = $signed(div_quo);
    if (sel_neg) qs = -($signed(div_quo) + NUM_WIDTH'(div_rem_nz));
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    acc_d   = acc_q;
    coord_d = coord_q;
    fault_d = fault_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          step_d  = '0;
          acc_d   = '0;
          fault_d = 1'b0;
          coord_d = '0;
          if (in_data_i.opcode == OP_CONCAT) state_d = S_CMAC;
          else if (in_data_i.opcode == OP_XFORM || in_data_i.opcode == OP_ROTATE ||
                   in_data_i.opcode == OP_ROT_XLAT) state_d = S_PMAC;
        end
      end
      S_CMAC, S_PMAC: begin
        step_d = step_q + 1'b1;
        if (mul_valid_q) acc_d = acc_q + acc_t'(prod_q);
        if (mul_valid_q && step_q[1:0] == 2'd1) acc_d = acc_t'(prod_q);
        if ((state_q == S_CMAC && step_q == 6'd0 && mul_valid_q) ||
            (state_q == S_PMAC && step_q == 6'd16)) begin
          state_d = (state_q == S_CMAC) ? S_IDLE : S_DIV;
          if (state_q == S_PMAC && op_q != OP_XFORM) state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (wacc == '0) begin
          fault_d = 1'b1;
          coord_d = coord_q + 1'b1;
          if (coord_q == 2'd2) state_d = S_OUT;
        end else state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_sts.done) begin
          if (sat_ovf32(qs)) fault_d = 1'b1;
          coord_d = coord_q + 1'b1;
          state_d = (coord_q == 2'd2) ? S_OUT : S_DIV;
        end
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // the product of step s is registered and lands in the next cycle; a group of four ends when the
  // registered product has k==3, i.e. the current step index low bits are 0
  logic [5:0] prev_step_q;
  logic       grp_end;
  assign grp_end = mul_valid_q && prev_step_q[1:0] == 2'd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      coord_q     <= '0;
      fault_q     <= 1'b0;
      ov_q        <= 1'b0;
      mul_valid_q <= 1'b0;
      op_q        <= '0;
      for (int e = 0; e < 16; e++) begin
        cur_q[e] <= ident_elem(4'(e));
        stg_q[e] <= ident_elem(4'(e));
      end
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      coord_q     <= coord_d;
      fault_q     <= fault_d;
      mul_valid_q <= ((state_q == S_CMAC) && !(step_q == 6'd0 && mul_valid_q)) ||
                     ((state_q == S_PMAC) && step_q != 6'd16);
      if (out_load) ov_q <= 1'b1;
      else if (out_valid_o && !out_stall_i) ov_q <= 1'b0;
      if (accept) begin
        op_q <= in_data_i.opcode;
        if (in_data_i.opcode == OP_LOAD)
          stg_q[in_data_i.element_index] <= in_data_i.element_value;
        if (in_data_i.opcode == OP_IDENTITY)
          for (int e = 0; e < 16; e++) cur_q[e] <= ident_elem(4'(e));
      end
      if (state_q == S_CMAC && grp_end)
        cur_q[prev_step_q[5:2]] <=
          sat_coeff(acc_t'((acc_q + acc_t'(prod_q)) >>> FRACTION_BITS));
    end
  end

  always_ff @(posedge clk_i) begin
    prev_step_q <= step_q;
    acc_q       <= acc_d;
    if (accept) begin
      pt_q[0] <= in_data_i.point_x;
      pt_q[1] <= in_data_i.point_y;
      pt_q[2] <= in_data_i.point_z;
      for (int e = 0; e < 16; e++) tmp_q[e] <= cur_q[e];
    end
    if (state_q == S_PMAC && grp_end) pacc_q[prev_step_q[3:2]] <= acc_q + acc_t'(prod_q);
    if (state_q == S_DIV && wacc == '0)
      res_q[coord_q] <= (cur_num == '0) ? 32'h0 :
                        (cur_num[ACC_WIDTH-1] ? 32'h8000_0000 : 32'h7fff_ffff);
    if (state_q == S_DWAIT && div_sts.done) res_q[coord_q] <= sat32(qs);
    if (out_load) begin
      if (op_q == OP_XFORM) begin
        obuf_q.result_x    <= res_q[0];
        obuf_q.result_y    <= res_q[1];
        obuf_q.result_z    <= res_q[2];
        obuf_q.range_fault <= fault_q;
      end else begin
        obuf_q.result_x    <= sat32(NUM_WIDTH'(pacc_q[0] >>> FRACTION_BITS));
        obuf_q.result_y    <= sat32(NUM_WIDTH'(pacc_q[1] >>> FRACTION_BITS));
        obuf_q.result_z    <= sat32(NUM_WIDTH'(pacc_q[2] >>> FRACTION_BITS));
        obuf_q.range_fault <= sat_ovf32(NUM_WIDTH'(pacc_q[0] >>> FRACTION_BITS)) ||
                              sat_ovf32(NUM_WIDTH'(pacc_q[1] >>> FRACTION_BITS)) ||
                              sat_ovf32(NUM_WIDTH'(pacc_q[2] >>> FRACTION_BITS));
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !accept) else $error("word taken while busy");
  a_out_after_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == S_OUT)) else $error("result without sequence");
  a_div_only_xform: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> op_q == OP_XFORM) else $error("divide outside transform");
endmodule
